FILE: rtl/polygon_centroid_fan_assert.svh
// assertion macros for the polygon centroid block
// used by the top level only; expects clk and rst_n in scope
`ifndef POLYGON_CENTROID_FAN_ASSERT_SVH
`define POLYGON_CENTROID_FAN_ASSERT_SVH
`ifndef SYNTHESIS
`define PCF_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pcf assertion failed");
`define PCF_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) else $error("pcf reset assertion failed");
`else
`define PCF_ASSERT(name, prop)
`define PCF_ASSERT_RST(name, prop)
`endif
`endif

FILE: rtl/pcf_pkg.sv
// shared constants and controller/datapath interface types
// no dependencies
`timescale 1ns / 1ps
package pcf_pkg;
  localparam int CNT_W = 11;
  localparam logic [CNT_W-1:0] MAX_VERTICES = 11'd1024;
  localparam int DIV_STEPS = 24;
  localparam int IT_W = 5;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_ZERO = 2'd2,
    ST_OVF  = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    MS_BQ = 2'd0,
    MS_QB = 2'd1,
    MS_SX = 2'd2,
    MS_SY = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     mul_en;
    logic     hold_en;
    logic     a2_en;
    logic     acc_x;
    logic     acc_y;
    logic     commit;
    logic     fin;
    logic     div_start;
    logic     div_sel;
    logic     div_step;
    logic     store_x;
    logic     store_y;
    logic     out_load;
    logic     clear;
  } cmd_t;

  typedef struct packed {
    logic do_acc;
    logic last;
    logic ok;
    logic div_done;
    logic out_free;
  } sts_t;
endpackage

FILE: rtl/polygon_centroid_fan.sv
// polygon centroid by triangle fan: top level joining controller and datapath
// depends on pcf_pkg, pcf_ctrl, pcf_dp and polygon_centroid_fan_assert.svh
//
// input stream: one vertex per transfer, x in in_tdata[15:0], y in [31:16],
// in_tlast marks the final vertex of a polygon.
// output stream: one transfer per polygon, sent after the last vertex.
// out_tdata holds centroid x (q16.8), centroid y (q16.8) and the doubled
// area; out_tuser carries the status (ok, under three vertices, zero area,
// too many vertices). on a nonzero status all data fields are zero.
// a vertex that only updates the fan apex or the previous vertex is just loaded
// and committed; one that closes a triangle takes four passes through one
// shared 35x18 multiplier plus accumulate and commit steps.
// the last vertex then gets a status step and, on a valid polygon, two restoring
// divides of a start, 24 one-bit steps and a store; the output load comes last.
// the output register holds a finished result while the next polygon's
// vertices come in; if it is still full when the next result is ready the
// block waits with in_tready low until out_tready takes it.
// reset (synchronous, rst_n low) clears all sums, the vertex count and the
// output valid; in_tready rises the cycle after reset is released.
`timescale 1ns / 1ps
`include "polygon_centroid_fan_assert.svh"
module polygon_centroid_fan import pcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // vertex_x, vertex_y
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // centroid_x, centroid_y, doubled_area, zero pad
  output logic [1:0]  out_tuser   // status
);
  cmd_t cmd;
  sts_t sts;

  pcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pcf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `PCF_ASSERT(a_ok_nonzero_area, out_tvalid && out_tuser == ST_OK |-> out_tdata[93:48] != '0)
  `PCF_ASSERT(a_err_zero_fields, out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
  `PCF_ASSERT(a_no_load_when_full, cmd.out_load |-> sts.out_free)
  `PCF_ASSERT_RST(a_reset_clears, !rst_n |=> !out_tvalid && !in_tready)
endmodule

FILE: rtl/pcf_dp.sv
// datapath: vertex registers, shared multiplier, accumulators, divider, output register
// depends on pcf_pkg
`timescale 1ns / 1ps
module pcf_dp import pcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,
  output logic [1:0]  out_tuser
);
  logic signed [15:0] cur_x_r, cur_y_r, first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic               last_r;
  logic [CNT_W-1:0]   cnt_r;
  logic signed [45:0] area_r;
  logic signed [63:0] wx_r, wy_r;
  logic signed [52:0] prod_r;
  logic signed [34:0] hold_r, a2_r;
  logic signed [34:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [16:0] bx, by, qx, qy;
  logic signed [17:0] sx, sy;
  stat_t              stat_r, stat_c;
  logic [46:0]        dm_r;
  logic               dneg_r, neg_r, sat_r;
  logic [46:0]        rem_r;
  logic [23:0]        low_r, q_r;
  logic [IT_W-1:0]    it_r;
  logic [23:0]        cx_r, cy_r;
  logic               out_valid_r;
  logic [95:0]        out_data_r;
  logic [1:0]         out_user_r;
  logic [47:0]        d3;
  logic [63:0]        w, m;
  logic [47:0]        t;
  logic               ge, big;
  logic [24:0]        q_ext;
  logic [23:0]        res;
  logic [45:0]        area_out;

  assign bx = {prev_x_r[15], prev_x_r} - {first_x_r[15], first_x_r};
  assign by = {prev_y_r[15], prev_y_r} - {first_y_r[15], first_y_r};
  assign qx = {cur_x_r[15], cur_x_r} - {first_x_r[15], first_x_r};
  assign qy = {cur_y_r[15], cur_y_r} - {first_y_r[15], first_y_r};
  assign sx = {{2{first_x_r[15]}}, first_x_r} + {{2{prev_x_r[15]}}, prev_x_r}
            + {{2{cur_x_r[15]}}, cur_x_r};
  assign sy = {{2{first_y_r[15]}}, first_y_r} + {{2{prev_y_r[15]}}, prev_y_r}
            + {{2{cur_y_r[15]}}, cur_y_r};

  always_comb begin
    case (cmd.mul_sel)
      MS_BQ: begin
        mul_a = {{18{bx[16]}}, bx};
        mul_b = {qy[16], qy};
      end
      MS_QB: begin
        mul_a = {{18{qx[16]}}, qx};
        mul_b = {by[16], by};
      end
      MS_SX: begin
        mul_a = a2_r;
        mul_b = sx;
      end
      MS_SY: begin
        mul_a = a2_r;
        mul_b = sy;
      end
      default: begin
        mul_a = a2_r;
        mul_b = sx;
      end
    endcase
  end

  always_comb begin
    if (cnt_r > MAX_VERTICES) stat_c = ST_OVF;
    else if (cnt_r < CNT_W'(3)) stat_c = ST_FEW;
    else if (area_r == '0) stat_c = ST_ZERO;
    else stat_c = ST_OK;
  end

  // 3 * area as 2a + a
  assign d3 = {area_r[45], area_r, 1'b0} + {{2{area_r[45]}}, area_r};
  assign w  = cmd.div_sel ? wy_r : wx_r;
  assign m  = w[63] ? 64'(-w) : w;

  assign t  = {rem_r, low_r[23]};
  assign ge = t >= {1'b0, dm_r};

  // saturate the magnitude to the q16.8 range
  assign q_ext = {1'b0, q_r};
  always_comb begin
    if (neg_r) begin
      big = sat_r || (q_ext > 25'd8388608);
      res = big ? 24'h800000 : 24'(-q_r);
    end else begin
      big = sat_r || (q_ext > 25'd8388607);
      res = big ? 24'h7fffff : q_r;
    end
  end

  assign area_out = (stat_r == ST_OK) ? area_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_x_r   <= '0;
      first_y_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      cnt_r       <= '0;
      area_r      <= '0;
      wx_r        <= '0;
      wy_r        <= '0;
      it_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        cur_x_r <= in_tdata[15:0];
        cur_y_r <= in_tdata[31:16];
        last_r  <= in_tlast;
      end
      if (cmd.mul_en) prod_r <= mul_a * mul_b;
      if (cmd.hold_en) hold_r <= prod_r[34:0];
      if (cmd.a2_en) a2_r <= hold_r - prod_r[34:0];
      if (cmd.acc_x) begin
        wx_r   <= wx_r + {{11{prod_r[52]}}, prod_r};
        area_r <= area_r + {{11{a2_r[34]}}, a2_r};
      end
      if (cmd.acc_y) wy_r <= wy_r + {{11{prod_r[52]}}, prod_r};
      if (cmd.commit) begin
        if (cnt_r < MAX_VERTICES) begin
          if (cnt_r == '0) begin
            first_x_r <= cur_x_r;
            first_y_r <= cur_y_r;
          end
          prev_x_r <= cur_x_r;
          prev_y_r <= cur_y_r;
          cnt_r    <= cnt_r + CNT_W'(1);
        end else begin
          cnt_r <= MAX_VERTICES + CNT_W'(1);
        end
      end
      if (cmd.fin) begin
        stat_r <= stat_c;
        dneg_r <= area_r[45];
        dm_r   <= area_r[45] ? 47'(-d3) : d3[46:0];
        cx_r   <= '0;
        cy_r   <= '0;
      end
      if (cmd.div_start) begin
        sat_r <= m[63:16] >= {1'b0, dm_r};
        rem_r <= m[62:16];
        low_r <= {m[15:0], 8'h00};
        neg_r <= w[63] ^ dneg_r;
        q_r   <= '0;
        it_r  <= '0;
      end
      if (cmd.div_step) begin
        rem_r <= ge ? 47'(t - {1'b0, dm_r}) : t[46:0];
        q_r   <= {q_r[22:0], ge};
        low_r <= {low_r[22:0], 1'b0};
        it_r  <= it_r + IT_W'(1);
      end
      if (cmd.store_x) cx_r <= res;
      if (cmd.store_y) cy_r <= res;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {2'b00, area_out, cy_r, cx_r};
        out_user_r  <= stat_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.clear) begin
        first_x_r <= '0;
        first_y_r <= '0;
        prev_x_r  <= '0;
        prev_y_r  <= '0;
        cnt_r     <= '0;
        area_r    <= '0;
        wx_r      <= '0;
        wy_r      <= '0;
      end
    end
  end

  assign sts.do_acc   = (cnt_r >= CNT_W'(2)) && (cnt_r < MAX_VERTICES);
  assign sts.last     = last_r;
  assign sts.ok       = (stat_c == ST_OK);
  assign sts.div_done = (it_r == IT_W'(DIV_STEPS - 1));
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
endmodule

FILE: rtl/pcf_ctrl.sv
// controller: sequences vertex accumulation, final divides and result handoff
// depends on pcf_pkg
`timescale 1ns / 1ps
module pcf_ctrl import pcf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [4:0] {
    S_IDLE, S_MA, S_MB, S_MD, S_MX, S_MY, S_MW, S_COMMIT, S_FIN,
    S_DXS, S_DXR, S_DXE, S_DYS, S_DYR, S_DYE, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   rdy_r, rdy_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && rdy_r) begin
          cmd.load  = 1'b1;
          state_nxt = sts.do_acc ? S_MA : S_COMMIT;
        end
      end
      S_MA: begin
        cmd.mul_sel = MS_BQ;
        cmd.mul_en  = 1'b1;
        state_nxt   = S_MB;
      end
      S_MB: begin
        cmd.mul_sel = MS_QB;
        cmd.mul_en  = 1'b1;
        cmd.hold_en = 1'b1;
        state_nxt   = S_MD;
      end
      S_MD: begin
        cmd.a2_en = 1'b1;
        state_nxt = S_MX;
      end
      S_MX: begin
        cmd.mul_sel = MS_SX;
        cmd.mul_en  = 1'b1;
        state_nxt   = S_MY;
      end
      S_MY: begin
        cmd.mul_sel = MS_SY;
        cmd.mul_en  = 1'b1;
        cmd.acc_x   = 1'b1;
        state_nxt   = S_MW;
      end
      S_MW: begin
        cmd.acc_y = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = sts.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = sts.ok ? S_DXS : S_OUT;
      end
      S_DXS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DXR;
      end
      S_DXR: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_DXE;
      end
      S_DXE: begin
        cmd.store_x = 1'b1;
        state_nxt   = S_DYS;
      end
      S_DYS: begin
        cmd.div_sel   = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = S_DYR;
      end
      S_DYR: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_DYE;
      end
      S_DYE: begin
        cmd.store_y = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    rdy_nxt = (state_nxt == S_IDLE) && !(state_r == S_IDLE && in_tvalid && rdy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rdy_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdy_r   <= rdy_nxt;
    end
  end

  assign in_tready = rdy_r;
endmodule

FILE: test/tb_polygon_centroid_fan.sv
// testbench for polygon_centroid_fan: vertex streams with random gaps and stalls,
// results checked against a behavioral centroid predictor
// depends on pcf_pkg and the polygon_centroid_fan rtl
`timescale 1ns / 1ps
module tb_polygon_centroid_fan;
  import pcf_pkg::*;

  localparam int MAXV = 1024;

  typedef struct {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [45:0] area;
    stat_t              st;
  } centroid_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
    logic               chk;   // typed-in expectation present
    centroid_t          res;
  } vrow_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [1:0]  out_tuser;

  polygon_centroid_fan dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic signed [15:0] apex_x, apex_y, prv_x, prv_y;
  int unsigned        nverts;
  logic signed [45:0] area_acc;
  logic signed [63:0] wx_acc, wy_acc;

  centroid_t pending_q[$];
  int errors = 0;
  int n_vertices = 0;
  int n_polys = 0;
  int n_checked = 0;
  int send_idle = 0, recv_idle = 0;

  function automatic logic signed [23:0] q8_quot(logic signed [63:0] w,
                                                 logic signed [63:0] d);
    logic        neg;
    logic [63:0] m, dm, q, r, mag;
    neg = (w < 0) != (d < 0);
    m = (w < 0) ? -w : w;
    dm = (d < 0) ? -d : d;
    q = m / dm;
    r = m % dm;
    if (q > 64'd32768) mag = 64'd8388608;
    else begin
      mag = q * 256 + (r * 256) / dm;
      if (mag > 64'd8388608) mag = 64'd8388608;
    end
    if (neg) return -$signed(mag[23:0]);
    if (mag > 64'd8388607) mag = 64'd8388607;
    return mag[23:0];
  endfunction

  function automatic void clear_fan();
    apex_x = 0; apex_y = 0; prv_x = 0; prv_y = 0;
    nverts = 0; area_acc = 0; wx_acc = 0; wy_acc = 0;
  endfunction

  // returns 1 when the vertex closes a polygon
  function automatic bit fan_vertex(logic signed [15:0] x, logic signed [15:0] y,
                                    logic last, output centroid_t res);
    logic signed [63:0] bx, by, qx, qy, a2, sx, sy, d;
    res = '{cx: 0, cy: 0, area: 0, st: ST_OK};
    if (nverts < MAXV) begin
      if (nverts == 0) begin
        apex_x = x; apex_y = y;
      end else if (nverts >= 2) begin
        bx = prv_x - apex_x; by = prv_y - apex_y;
        qx = x - apex_x;     qy = y - apex_y;
        a2 = bx * qy - qx * by;
        sx = 64'(apex_x) + prv_x + x;
        sy = 64'(apex_y) + prv_y + y;
        area_acc += a2[45:0];
        wx_acc += a2 * sx;
        wy_acc += a2 * sy;
      end
      prv_x = x; prv_y = y;
      nverts++;
    end else nverts = MAXV + 1;
    if (!last) return 0;
    if (nverts > MAXV) res.st = ST_OVF;
    else if (nverts < 3) res.st = ST_FEW;
    else if (area_acc == 0) res.st = ST_ZERO;
    else begin
      d = 3 * 64'(area_acc);
      res.area = area_acc;
      res.cx = q8_quot(wx_acc, d);
      res.cy = q8_quot(wy_acc, d);
    end
    clear_fan();
    return 1;
  endfunction

  // starts and ends at a falling edge; in_tvalid stays high on return
  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, logic last);
    centroid_t res;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_vertices++;
    if (fan_vertex(x, y, last, res)) begin
      pending_q = {pending_q, res};
      n_polys++;
    end
    @(negedge clk);
  endtask

  task automatic send_poly(int n, int mode);
    logic signed [15:0] x, y, cx0, cy0;
    int r;
    cx0 = 16'($urandom); cy0 = 16'($urandom);
    r = $urandom_range(1, 16) << $urandom_range(0, 11);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: begin x = 16'($urandom); y = 16'($urandom); end
        1: begin // near-convex ring, mostly positive area
          x = 16'(cx0 + int'(r * $cos(6.2832 * i / n)));
          y = 16'(cy0 + int'(r * $sin(6.2832 * i / n)));
        end
        default: begin x = 16'($urandom_range(0, 3) * 16'h7fff); y = x; end // collinear
      endcase
      send_vertex(x, y, i == n - 1);
    end
  endtask

  // output checker
  always @(posedge clk) begin
    centroid_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      n_checked++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result data=%h status=%0d", $time, out_tdata, out_tuser);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (out_tdata[23:0] !== exp_r.cx || out_tdata[47:24] !== exp_r.cy ||
            out_tdata[93:48] !== exp_r.area || out_tdata[95:94] !== 2'b00 ||
            out_tuser !== exp_r.st) begin
          $display("%0t: mismatch expected cx=%0d cy=%0d area=%0d st=%0d",
                   $time, exp_r.cx, exp_r.cy, exp_r.area, exp_r.st);
          $display("%0t:          actual   cx=%0d cy=%0d area=%0d st=%0d", $time,
                   $signed(out_tdata[23:0]), $signed(out_tdata[47:24]),
                   $signed(out_tdata[93:48]), out_tuser);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_tready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
  end

  // directed table; chk rows carry a typed-in result
  vrow_t dir_rows[] = '{
    '{16'sd5, 16'sd5, 1'b1, 1'b1, '{0, 0, 0, ST_FEW}},
    '{16'sd0, 16'sd0, 1'b0, 1'b0, '{0, 0, 0, ST_OK}},
    '{16'sd1, 16'sd1, 1'b1, 1'b1, '{0, 0, 0, ST_FEW}},
    '{16'sd0, 16'sd0, 1'b0, 1'b0, '{0, 0, 0, ST_OK}},
    '{16'sd1, 16'sd1, 1'b0, 1'b0, '{0, 0, 0, ST_OK}},
    '{16'sd2, 16'sd2, 1'b1, 1'b1, '{0, 0, 0, ST_ZERO}},
    '{16'sd0, 16'sd0, 1'b0, 1'b0, '{0, 0, 0, ST_OK}},
    '{16'sd3, 16'sd0, 1'b0, 1'b0, '{0, 0, 0, ST_OK}},
    '{16'sd0, 16'sd3, 1'b1, 1'b1, '{24'sd256, 24'sd256, 46'sd9, ST_OK}},
    '{-16'sd32768, -16'sd32768, 1'b0, 1'b0, '{0, 0, 0, ST_OK}},
    '{16'sd32767, -16'sd32768, 1'b0, 1'b0, '{0, 0, 0, ST_OK}},
    '{16'sd32767, 16'sd32767, 1'b0, 1'b0, '{0, 0, 0, ST_OK}},
    '{-16'sd32768, 16'sd32767, 1'b1, 1'b0, '{0, 0, 0, ST_OK}},
    '{16'sd32767, 16'sd32767, 1'b0, 1'b0, '{0, 0, 0, ST_OK}},
    '{-16'sd32768, 16'sd32767, 1'b0, 1'b0, '{0, 0, 0, ST_OK}},
    '{-16'sd32768, -16'sd32768, 1'b1, 1'b0, '{0, 0, 0, ST_OK}},
    '{16'sd0, 16'sd0, 1'b0, 1'b0, '{0, 0, 0, ST_OK}},
    '{16'sd0, 16'sd1, 1'b0, 1'b0, '{0, 0, 0, ST_OK}},
    '{16'sd1, 16'sd0, 1'b1, 1'b0, '{0, 0, 0, ST_OK}},
    '{16'sd32767, 16'sd32767, 1'b0, 1'b0, '{0, 0, 0, ST_OK}},
    '{16'sd32766, 16'sd32767, 1'b0, 1'b0, '{0, 0, 0, ST_OK}},
    '{16'sd32767, 16'sd32766, 1'b1, 1'b0, '{0, 0, 0, ST_OK}}
  };

  initial begin
    int ph_idle[3][2] = '{'{24, 46}, '{46, 24}, '{0, 0}};
    int k;
    clear_fan();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_vertex(dir_rows[i].x, dir_rows[i].y, dir_rows[i].last);
      if (dir_rows[i].last && dir_rows[i].chk &&
          (pending_q[$].cx !== dir_rows[i].res.cx ||
           pending_q[$].cy !== dir_rows[i].res.cy ||
           pending_q[$].area !== dir_rows[i].res.area ||
           pending_q[$].st !== dir_rows[i].res.st)) begin
        $display("%0t: table row %0d disagrees with predictor", $time, i);
        errors++;
      end
    end

    // overflow polygon: count reaches the limit, then saturates
    for (int i = 0; i < MAXV + 2; i++)
      send_vertex(16'($urandom), 16'($urandom), i == MAXV + 1);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph_idle[ph][0];
      recv_idle = ph_idle[ph][1];
      k = 0;
      while (k < 165) begin
        int n, m;
        n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
        m = $urandom_range(9);
        send_poly(n, m < 6 ? 1 : (m < 9 ? 0 : 2));
        k += n;
        if ($urandom_range(4) == 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 10)) @(negedge clk);
        end
      end
    end
    in_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d vertices in %0d polygons, %0d results checked",
             n_vertices, n_polys, n_checked);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("Verification failed");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/pcf_pkg.sv
rtl/pcf_dp.sv
rtl/pcf_ctrl.sv
rtl/polygon_centroid_fan.sv
test/tb_polygon_centroid_fan.sv
